// ===== hdl/lfpr_pkg.sv =====
// Package for the length-framed packet receiver: phase and status codes,
// request kinds, register indexes and the bytewise CRC-16/MODBUS update.
// No dependencies.
`default_nettype none

package lfpr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_DATA = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC      = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Request kind on the slave side
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kind on the master side
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_END     = 1'b1;

  // Register indexes on the configuration port
  localparam logic CFG_PREAMBLE = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] PREAMBLE_RESET = 8'd170;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // CRC-16/MODBUS, reflected, one byte: eight shift-and-xor steps
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/length_framed_packet_receiver_core.sv =====
// Top level of the length-framed packet receiver: frame state machine,
// CRC check, tick timeout and the result register. Depends on lfpr_pkg.
`default_nettype none

// Length-framed packet receiver. Each request on the slave side is either a
// received byte (tuser = 0) or one time tick with no byte (tuser = 1). While
// idle the block drops bytes equal to the preamble register; any other byte
// is the frame length L, followed by a command byte, max(1, L-2) payload
// bytes (L < 2: until overflow) and a CRC-16/MODBUS sent high byte first.
// The CRC covers length, command and the first L-2 payload bytes. Each
// payload byte leaves at once as a payload result (tuser = 0); the CRC low
// byte gives an end result (tuser = 1) with status OK or CRC mismatch. The
// payload byte that brings the count to MAX_DATA gives an overflow end
// result carrying that byte and its index instead. A tick that arrives once
// the tick count since the last byte has reached the timeout register gives
// a timeout end result in any phase, idle included. Every end result
// returns the frame state to reset. Rate: one request per clock cycle. The
// whole update (eight unrolled CRC steps, compares, next phase) sits
// between the state registers and a single result register; a new request
// is taken whenever that register is empty or being drained in the same
// cycle, so with the master side ready the block sustains one request per
// cycle. A register write takes effect at the next cycle; write the
// registers only while no frame or result is in flight.
module length_framed_packet_receiver_core #(
  parameter int MAX_DATA = 32  // payload bytes that trigger overflow, 2..253
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] req_type
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                      // [23:16] frame_command, [31:24] frame_length,
                                      // [33:32] frame_status, [39:34] zero
  output logic             m_tuser,   // [0] result_kind
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index, // 0 preamble_value, 1 timeout_limit
  input  wire logic [15:0] cfg_data
);

  localparam logic [8:0] MAX_CNT = 9'(MAX_DATA);

  // configuration registers
  logic [7:0]  preamble_value;
  logic [15:0] timeout_limit;

  // frame state
  lfpr_pkg::phase_t phase, phase_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  command_held, command_held_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  crc_high_held, crc_high_held_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  // result register
  logic        out_valid;
  logic        out_kind, out_kind_next;
  logic [7:0]  out_byte, out_byte_next;
  logic [7:0]  out_index, out_index_next;
  logic [7:0]  out_cmd, out_cmd_next;
  logic [7:0]  out_len, out_len_next;
  lfpr_pkg::status_t out_status, out_status_next;
  logic        emit;

  logic        accept;
  logic        is_tick;
  logic        timed_out;
  logic [8:0]  cnt_ext;
  logic        overflow;
  logic        crc_covers;
  logic        last_payload;
  logic        crc_match;
  logic [15:0] crc_step;

  // Take a request whenever the result register is free or drains now
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_tick  = (s_tuser == lfpr_pkg::REQ_TICK);

  assign timed_out    = (idle_ticks >= timeout_limit);
  assign cnt_ext      = {1'b0, payload_count} + 9'd1;
  assign overflow     = (cnt_ext >= MAX_CNT);
  // payload byte at index idx is covered while idx + 2 < L
  assign crc_covers   = ({1'b0, payload_count} + 9'd2) < {1'b0, length_held};
  // last payload byte once count + 2 reaches L (only for L of 2 or more)
  assign last_payload = (length_held >= 8'd2) &&
                        ((cnt_ext + 9'd2) >= {1'b0, length_held});
  assign crc_match    = ({crc_high_held, s_tdata} == crc_running);

  // Length byte seeds from init; later bytes extend the running value
  assign crc_step = lfpr_pkg::crc16_update(
                      (phase == lfpr_pkg::PH_CMD || phase == lfpr_pkg::PH_DATA) ?
                      crc_running : lfpr_pkg::CRC_INIT, s_tdata);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (is_tick) begin
        if (timed_out) begin
          phase_next = lfpr_pkg::PH_IDLE;
        end
      end else begin
        unique case (phase)
          lfpr_pkg::PH_CMD:  phase_next = lfpr_pkg::PH_DATA;
          lfpr_pkg::PH_DATA: begin
            if (overflow) begin
              phase_next = lfpr_pkg::PH_IDLE;
            end else if (last_payload) begin
              phase_next = lfpr_pkg::PH_CRCH;
            end
          end
          lfpr_pkg::PH_CRCH: phase_next = lfpr_pkg::PH_CRCL;
          lfpr_pkg::PH_CRCL: phase_next = lfpr_pkg::PH_IDLE;
          default: begin
            phase_next = (s_tdata != preamble_value) ? lfpr_pkg::PH_CMD :
                                                       lfpr_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    length_held_next   = length_held;
    command_held_next  = command_held;
    payload_count_next = payload_count;
    crc_running_next   = crc_running;
    crc_high_held_next = crc_high_held;
    idle_ticks_next    = idle_ticks;
    emit               = 1'b0;
    out_kind_next      = lfpr_pkg::RES_END;
    out_byte_next      = 8'd0;
    out_index_next     = 8'd0;
    out_cmd_next       = command_held;
    out_len_next       = length_held;
    out_status_next    = lfpr_pkg::ST_OK;

    if (accept) begin
      if (is_tick) begin
        if (timed_out) begin
          emit            = 1'b1;
          out_status_next = lfpr_pkg::ST_TIMEOUT;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end else begin
        idle_ticks_next = '0;
        unique case (phase)
          lfpr_pkg::PH_CMD: begin
            command_held_next = s_tdata;
            crc_running_next  = crc_step;
          end
          lfpr_pkg::PH_DATA: begin
            if (crc_covers) begin
              crc_running_next = crc_step;
            end
            emit           = 1'b1;
            out_byte_next  = s_tdata;
            out_index_next = payload_count;
            if (overflow) begin
              out_status_next = lfpr_pkg::ST_OVERFLOW;
            end else begin
              out_kind_next      = lfpr_pkg::RES_PAYLOAD;
              payload_count_next = cnt_ext[7:0];
            end
          end
          lfpr_pkg::PH_CRCH: crc_high_held_next = s_tdata;
          lfpr_pkg::PH_CRCL: begin
            emit            = 1'b1;
            out_status_next = crc_match ? lfpr_pkg::ST_OK : lfpr_pkg::ST_CRC;
          end
          default: begin
            if (s_tdata != preamble_value) begin
              length_held_next   = s_tdata;
              crc_running_next   = crc_step;
              payload_count_next = '0;
            end
          end
        endcase
      end

      // Any end result drops the frame back to its reset values
      if (emit && out_kind_next == lfpr_pkg::RES_END) begin
        length_held_next   = '0;
        command_held_next  = '0;
        payload_count_next = '0;
        crc_running_next   = lfpr_pkg::CRC_INIT;
        crc_high_held_next = '0;
        idle_ticks_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_value <= lfpr_pkg::PREAMBLE_RESET;
      timeout_limit  <= lfpr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfpr_pkg::CFG_PREAMBLE: preamble_value <= cfg_data[7:0];
        lfpr_pkg::CFG_TIMEOUT:  timeout_limit  <= cfg_data;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lfpr_pkg::PH_IDLE;
      length_held   <= '0;
      command_held  <= '0;
      payload_count <= '0;
      crc_running   <= lfpr_pkg::CRC_INIT;
      crc_high_held <= '0;
      idle_ticks    <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      length_held   <= length_held_next;
      command_held  <= command_held_next;
      payload_count <= payload_count_next;
      crc_running   <= crc_running_next;
      crc_high_held <= crc_high_held_next;
      idle_ticks    <= idle_ticks_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on a new result, hold otherwise
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= out_kind_next;
      out_byte   <= out_byte_next;
      out_index  <= out_index_next;
      out_cmd    <= out_cmd_next;
      out_len    <= out_len_next;
      out_status <= out_status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_status, out_len, out_cmd, out_index, out_byte};

  // The payload count never reaches the overflow point inside a frame
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, payload_count} < MAX_CNT)
    else $error("payload count reached MAX_DATA");

  // An expired tick must produce a timeout end result next cycle
  a_timeout_result: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick && timed_out |=>
      m_tvalid && m_tuser == lfpr_pkg::RES_END &&
      m_tdata[33:32] == lfpr_pkg::ST_TIMEOUT)
    else $error("expired tick gave no timeout result");

  // An end result leaves the frame state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    emit && out_kind_next == lfpr_pkg::RES_END |=>
      phase == lfpr_pkg::PH_IDLE && crc_running == lfpr_pkg::CRC_INIT &&
      payload_count == 8'd0 && idle_ticks == 16'd0)
    else $error("frame state not cleared after end result");

  // A result is only produced when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || m_tready)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
